// ===== rtl/lhpf_pkg.sv =====
// Shared types, constants and the control program for the ladder highpass filter.
// Used by lhpf_seq, lhpf_datapath and ladder_highpass_filter_top; depends on nothing.
package lhpf_pkg;

    // Default sizes and fixed formats
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int GAIN_WIDTH         = 16;
    localparam int GAIN_FRAC_BITS     = 12;
    localparam int NUM_POLES          = 4;
    localparam int POLE_IDX_W         = 2;
    localparam int STEP_W             = 4;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_POLE_COEF     = 1'b0,
        REG_FEEDBACK_GAIN = 1'b1
    } cfg_reg_t;

    // Multiplier operand A sources
    typedef enum logic [1:0] {
        A_POLE = 2'd0,
        A_D    = 2'd1,
        A_X2   = 2'd2,
        A_Y    = 2'd3
    } a_sel_t;

    // Multiplier operand B sources
    typedef enum logic [1:0] {
        B_GAIN = 2'd0,
        B_D    = 2'd1,
        B_COEF = 2'd2,
        B_OMC  = 2'd3
    } b_sel_t;

    typedef enum logic [0:0] {
        ACC_HOLD = 1'b0,
        ACC_LOAD = 1'b1
    } acc_op_t;

    // Writeback operations
    typedef enum logic [2:0] {
        WB_NONE = 3'd0,
        WB_IN   = 3'd1,
        WB_D    = 3'd2,
        WB_X2   = 3'd3,
        WB_Y    = 3'd4,
        WB_POLE = 3'd5,
        WB_OUT  = 3'd6
    } wb_op_t;

    // Conditions that hold the step counter on the current step
    typedef enum logic [1:0] {
        WAIT_NONE   = 2'd0,
        WAIT_INPUT  = 2'd1,
        WAIT_OUTPUT = 2'd2
    } wait_t;

    // One control word
    typedef struct packed {
        a_sel_t                  a_sel;
        b_sel_t                  b_sel;
        logic [POLE_IDX_W-1:0]   mul_pole;
        acc_op_t                 acc_op;
        wb_op_t                  wb_op;
        logic [POLE_IDX_W-1:0]   wb_pole;
        wait_t                   wait_on;
        logic                    last;
    } ctrl_t;

    // Handshake status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } stat_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic ctrl_t cw(
        input a_sel_t                a,
        input b_sel_t                b,
        input logic [POLE_IDX_W-1:0] mp,
        input acc_op_t               acc,
        input wb_op_t                wb,
        input logic [POLE_IDX_W-1:0] wp,
        input wait_t                 wt,
        input logic                  last
    );
        ctrl_t w;
        w.a_sel    = a;
        w.b_sel    = b;
        w.mul_pole = mp;
        w.acc_op   = acc;
        w.wb_op    = wb;
        w.wb_pole  = wp;
        w.wait_on  = wt;
        w.last     = last;
        return w;
    endfunction

    // Control program. A product issued in one step is read in the next.
    // Each pole takes two steps: p*c lands in the accumulator, then
    // in*(one-c) is added and the sum is rounded into the pole.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        unique case (step)
            // wait for a word; multiply fourth pole by the gain
            4'd0:  w = cw(A_POLE, B_GAIN, 2'd3, ACC_HOLD, WB_IN,   2'd0, WAIT_INPUT,  1'b0);
            // subtract feedback and clamp
            4'd1:  w = cw(A_D,    B_D,    2'd0, ACC_HOLD, WB_D,    2'd0, WAIT_NONE,   1'b0);
            4'd2:  w = cw(A_D,    B_D,    2'd0, ACC_HOLD, WB_NONE, 2'd0, WAIT_NONE,   1'b0);
            4'd3:  w = cw(A_D,    B_D,    2'd0, ACC_HOLD, WB_X2,   2'd0, WAIT_NONE,   1'b0);
            4'd4:  w = cw(A_X2,   B_D,    2'd0, ACC_HOLD, WB_NONE, 2'd0, WAIT_NONE,   1'b0);
            // soft clip; start first pole
            4'd5:  w = cw(A_POLE, B_COEF, 2'd0, ACC_HOLD, WB_Y,    2'd0, WAIT_NONE,   1'b0);
            4'd6:  w = cw(A_Y,    B_OMC,  2'd0, ACC_LOAD, WB_NONE, 2'd0, WAIT_NONE,   1'b0);
            4'd7:  w = cw(A_POLE, B_COEF, 2'd1, ACC_HOLD, WB_POLE, 2'd0, WAIT_NONE,   1'b0);
            4'd8:  w = cw(A_POLE, B_OMC,  2'd0, ACC_LOAD, WB_NONE, 2'd0, WAIT_NONE,   1'b0);
            4'd9:  w = cw(A_POLE, B_COEF, 2'd2, ACC_HOLD, WB_POLE, 2'd1, WAIT_NONE,   1'b0);
            4'd10: w = cw(A_POLE, B_OMC,  2'd1, ACC_LOAD, WB_NONE, 2'd0, WAIT_NONE,   1'b0);
            4'd11: w = cw(A_POLE, B_COEF, 2'd3, ACC_HOLD, WB_POLE, 2'd2, WAIT_NONE,   1'b0);
            4'd12: w = cw(A_POLE, B_OMC,  2'd2, ACC_LOAD, WB_NONE, 2'd0, WAIT_NONE,   1'b0);
            4'd13: w = cw(A_D,    B_D,    2'd0, ACC_HOLD, WB_POLE, 2'd3, WAIT_NONE,   1'b0);
            // form the output once the output register is free
            4'd14: w = cw(A_D,    B_D,    2'd0, ACC_HOLD, WB_OUT,  2'd0, WAIT_OUTPUT, 1'b1);
            default: w = cw(A_D,  B_D,    2'd0, ACC_HOLD, WB_NONE, 2'd0, WAIT_NONE,   1'b1);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/ladder_highpass_filter_top.sv =====
// One word at a time: the 15-step control program around one shared
// multiplier accepts a new word only at its first step, where it stalls for
// input, and its last step stalls while the output word is still waiting.
// Reset (aresetn, synchronous, active low): poles cleared, pole_coef = 1.0,
// feedback_gain = 0, sequencer at its first step, output empty.
// Depends on lhpf_pkg, lhpf_seq and lhpf_datapath.
module ladder_highpass_filter_top #(
    parameter int SAMPLE_WIDTH   = lhpf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = lhpf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_sample_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_WIDTH:0]      m_sample_out,
    input  logic                              cfg_wr_en,
    input  logic [0:0]                        cfg_addr,
    input  logic [lhpf_pkg::max2(COEF_FRAC_BITS + 1, lhpf_pkg::GAIN_WIDTH)-1:0] cfg_wdata
);

    localparam int CF = COEF_FRAC_BITS;
    localparam int GW = lhpf_pkg::GAIN_WIDTH;
    localparam logic [CF:0] ONE = (CF + 1)'(1) << CF;

    logic [CF:0]       coef_reg, coef_next;
    logic [CF:0]       omc_reg, omc_next;
    logic [GW-1:0]     gain_reg, gain_next;
    logic [CF:0]       wr_coef;
    logic [CF:0]       wr_sat;
    logic              m_valid_reg, m_valid_next;
    lhpf_pkg::ctrl_t   ctrl;
    lhpf_pkg::stat_t   stat;
    logic              fire;
    logic              accept;
    logic              out_load;

    // Saturate the coefficient to one and keep one minus it alongside
    assign wr_coef = cfg_wdata[CF:0];
    assign wr_sat  = (wr_coef > ONE) ? ONE : wr_coef;

    always_comb begin
        coef_next = coef_reg;
        omc_next  = omc_reg;
        gain_next = gain_reg;
        if (cfg_wr_en) begin
            unique case (lhpf_pkg::cfg_reg_t'(cfg_addr))
                lhpf_pkg::REG_POLE_COEF: begin
                    coef_next = wr_sat;
                    omc_next  = ONE - wr_sat;
                end
                lhpf_pkg::REG_FEEDBACK_GAIN: begin
                    gain_next = cfg_wdata[GW-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= ONE;
            omc_reg  <= '0;
            gain_reg <= '0;
        end else begin
            coef_reg <= coef_next;
            omc_reg  <= omc_next;
            gain_reg <= gain_next;
        end
    end

    // Handshake status for the sequencer
    assign stat.in_valid = s_valid;
    assign stat.out_busy = m_valid_reg && !m_ready;

    assign s_ready  = (ctrl.wb_op == lhpf_pkg::WB_IN);
    assign accept   = s_valid && s_ready;
    assign out_load = fire && (ctrl.wb_op == lhpf_pkg::WB_OUT);

    // Hold the output word until taken
    always_comb begin
        priority if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    lhpf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl),
        .fire    (fire)
    );

    lhpf_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .fire       (fire),
        .sample_in  (s_sample_in),
        .coef       (coef_reg),
        .omc        (omc_reg),
        .gain       (gain_reg),
        .sample_out (m_sample_out)
    );

`ifndef NO_ASSERTIONS
    // Never overwrite a word that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(m_valid_reg && !m_ready))
        else $error("output word overwritten while stalled");

    // A new word shows up only after the output step ran
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(out_load))
        else $error("m_valid rose without an output step");

    // One word at a time: no input taken right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted while a word is in flight");
`endif

endmodule

// ===== rtl/lhpf_seq.sv =====
// Step counter and control store for the ladder highpass filter.
// Depends on lhpf_pkg for the control word, status struct and program.
module lhpf_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  lhpf_pkg::stat_t  stat,
    output lhpf_pkg::ctrl_t  ctrl,
    output logic             fire
);

    logic [lhpf_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        stall;

    // Read the control word for the current step
    assign ctrl = lhpf_pkg::ucode(step_reg);

    // Hold the step while its wait condition is true
    always_comb begin
        unique case (ctrl.wait_on)
            lhpf_pkg::WAIT_NONE:   stall = 1'b0;
            lhpf_pkg::WAIT_INPUT:  stall = !stat.in_valid;
            lhpf_pkg::WAIT_OUTPUT: stall = stat.out_busy;
            default:               stall = 1'b0;
        endcase
    end

    assign fire = !stall;

    // Advance, jump back to the first step, or hold
    always_comb begin
        priority if (stall) begin
            step_next = step_reg;
        end else if (ctrl.last) begin
            step_next = '0;
        end else begin
            step_next = step_reg + lhpf_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/lhpf_datapath.sv =====
// Shared multiplier, accumulator, rounding and pole registers of the ladder highpass filter.
// Driven by control words from lhpf_seq; depends on lhpf_pkg.
module lhpf_datapath #(
    parameter int SAMPLE_WIDTH   = lhpf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = lhpf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lhpf_pkg::ctrl_t                     ctrl,
    input  logic                                fire,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
    input  logic [COEF_FRAC_BITS:0]             coef,
    input  logic [COEF_FRAC_BITS:0]             omc,
    input  logic [lhpf_pkg::GAIN_WIDTH-1:0]     gain,
    output logic signed [SAMPLE_WIDTH:0]        sample_out
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int F     = SAMPLE_WIDTH - 1;
    localparam int CF    = COEF_FRAC_BITS;
    localparam int GF    = lhpf_pkg::GAIN_FRAC_BITS;
    localparam int NP    = lhpf_pkg::NUM_POLES;
    localparam int AW    = SW + 2;
    localparam int BW    = lhpf_pkg::max2(lhpf_pkg::max2(SW + 1, CF + 2),
                                          lhpf_pkg::GAIN_WIDTH + 1);
    localparam int PW    = AW + BW;
    localparam int ACC_W = PW + 1;
    localparam int TW    = SW + 3;

    localparam logic signed [PW-1:0]    HALF_G = PW'(1) << (GF - 1);
    localparam logic signed [PW-1:0]    HALF_F = PW'(1) << (F - 1);
    localparam logic signed [ACC_W-1:0] HALF_C = ACC_W'(1) << (CF - 1);
    localparam logic signed [PW:0]      LIM_D  = (PW + 1)'(1) << F;
    localparam logic signed [TW-1:0]    OMAX   = (TW'(1) << SW) - TW'(1);
    localparam logic signed [TW-1:0]    OMIN   = -(TW'(1) << SW);

    logic signed [SW-1:0]  smp_reg, smp_next;
    logic signed [SW:0]    d_reg, d_next;
    logic signed [SW:0]    x2_reg, x2_next;
    logic signed [SW:0]    y_reg, y_next;
    logic signed [SW:0]    out_reg, out_next;
    logic signed [SW+1:0]  pole_reg [NP];
    logic signed [SW+1:0]  pole_next [NP];
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [PW-1:0]  prod_reg;

    logic signed [AW-1:0]  a_op;
    logic signed [BW-1:0]  b_op;
    logic signed [PW-1:0]  fb;
    logic signed [PW:0]    diff;
    logic signed [SW:0]    d_clamp;
    logic signed [PW-1:0]  prod_f;
    logic signed [TW-1:0]  x3;
    logic signed [TW-1:0]  td;
    logic signed [TW-1:0]  t;
    logic signed [TW-1:0]  y_full;
    logic signed [ACC_W-1:0] pole_sum;
    logic signed [TW-1:0]  r;
    logic signed [SW:0]    r_sat;

    // Select multiplier operands
    always_comb begin
        unique case (ctrl.a_sel)
            lhpf_pkg::A_POLE: a_op = pole_reg[ctrl.mul_pole];
            lhpf_pkg::A_D:    a_op = AW'(d_reg);
            lhpf_pkg::A_X2:   a_op = AW'(x2_reg);
            lhpf_pkg::A_Y:    a_op = AW'(y_reg);
        endcase
    end

    always_comb begin
        unique case (ctrl.b_sel)
            lhpf_pkg::B_GAIN: b_op = BW'(gain);
            lhpf_pkg::B_D:    b_op = BW'(d_reg);
            lhpf_pkg::B_COEF: b_op = BW'(coef);
            lhpf_pkg::B_OMC:  b_op = BW'(omc);
        endcase
    end

    // Register every product
    always_ff @(posedge aclk) begin
        prod_reg <= a_op * b_op;
    end

    // Feedback subtract and clamp to plus or minus one
    assign fb   = (prod_reg + HALF_G) >>> GF;
    assign diff = (PW + 1)'(smp_reg) - (PW + 1)'(fb);

    always_comb begin
        priority if (diff > LIM_D) begin
            d_clamp = LIM_D[SW:0];
        end else if (diff < -LIM_D) begin
            d_clamp = -LIM_D[SW:0];
        end else begin
            d_clamp = diff[SW:0];
        end
    end

    // Soft clip: y = (3d - d^3) / 2, rounded
    assign prod_f = (prod_reg + HALF_F) >>> F;
    assign x3     = prod_f[TW-1:0];
    assign td     = TW'(d_reg);
    assign t      = td + (td <<< 1) - x3;
    assign y_full = (t + TW'(1)) >>> 1;

    // Pole update: round (p*c + in*(one-c)) back to sample scale
    assign pole_sum = (acc_reg + ACC_W'(prod_reg)) >>> CF;

    // Output: shaped value minus fourth pole, saturated
    assign r = TW'(y_reg) - TW'(pole_reg[NP-1]);

    always_comb begin
        priority if (r > OMAX) begin
            r_sat = OMAX[SW:0];
        end else if (r < OMIN) begin
            r_sat = OMIN[SW:0];
        end else begin
            r_sat = r[SW:0];
        end
    end

    // Writeback
    always_comb begin
        smp_next  = smp_reg;
        d_next    = d_reg;
        x2_next   = x2_reg;
        y_next    = y_reg;
        out_next  = out_reg;
        acc_next  = acc_reg;
        pole_next = pole_reg;
        if (fire) begin
            unique case (ctrl.wb_op)
                lhpf_pkg::WB_NONE: ;
                lhpf_pkg::WB_IN:   smp_next = sample_in;
                lhpf_pkg::WB_D:    d_next   = d_clamp;
                lhpf_pkg::WB_X2:   x2_next  = prod_f[SW:0];
                lhpf_pkg::WB_Y:    y_next   = y_full[SW:0];
                lhpf_pkg::WB_POLE: pole_next[ctrl.wb_pole] = pole_sum[SW+1:0];
                lhpf_pkg::WB_OUT:  out_next = r_sat;
                default: ;
            endcase
            if (ctrl.acc_op == lhpf_pkg::ACC_LOAD) begin
                acc_next = ACC_W'(prod_reg) + HALF_C;
            end
        end
    end

    always_ff @(posedge aclk) begin
        smp_reg <= smp_next;
        d_reg   <= d_next;
        x2_reg  <= x2_next;
        y_reg   <= y_next;
        out_reg <= out_next;
        acc_reg <= acc_next;
    end

    // Clear the poles on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NP; i++) begin
                pole_reg[i] <= '0;
            end
        end else begin
            pole_reg <= pole_next;
        end
    end

    assign sample_out = out_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ladder_highpass_filter_top: bursty driver, stalling monitor and
// a bit-exact fixed-point filter predictor. Depends on lhpf_pkg and the RTL top.
module tb_top;

    localparam int SW    = 24;
    localparam int FB    = SW - 1;
    localparam int CF    = 16;
    localparam int GF    = 12;
    localparam int CFG_W = 17;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic signed [SW-1:0] s_sample_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [SW:0]   m_sample_out;
    logic              cfg_wr_en = 1'b0;
    logic [0:0]        cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // Filter state and register copies of the predictor
    longint            ladder_pole [4];
    logic [CFG_W-1:0]  coef_shadow;
    logic [15:0]       gain_shadow;

    logic signed [SW-1:0] pending_samples [$];
    logic signed [SW:0]   expected_out [$];
    int                mismatch_count = 0;

    int                burst_left;
    int                gap_left;
    int                hold_req = 0;
    int                hold_served;
    int                hold_left;
    int                ready_mode;
    int                ready_left;

    ladder_highpass_filter_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shift right by s, rounding half toward plus infinity
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Advance the filter by one sample and return the highpass output
    function automatic logic signed [SW:0] ladder_step(input logic signed [SW-1:0] smp);
        longint lim;
        longint c;
        longint d;
        longint x2;
        longint x3;
        longint y;
        longint stage_in;
        longint r;
        lim = longint'(1) << FB;
        c = longint'(coef_shadow);
        if (c > (longint'(1) << CF))
            c = longint'(1) << CF;
        d = longint'(smp) - round_shift(ladder_pole[3] * longint'(gain_shadow), GF);
        if (d > lim)
            d = lim;
        if (d < -lim)
            d = -lim;
        x2 = round_shift(d * d, FB);
        x3 = round_shift(x2 * d, FB);
        y = round_shift(3 * d - x3, 1);
        stage_in = y;
        for (int k = 0; k < 4; k++) begin
            ladder_pole[k] = round_shift(stage_in * ((longint'(1) << CF) - c)
                                         + ladder_pole[k] * c, CF);
            stage_in = ladder_pole[k];
        end
        r = y - ladder_pole[3];
        if (r > (longint'(1) << SW) - 1)
            r = (longint'(1) << SW) - 1;
        if (r < -(longint'(1) << SW))
            r = -(longint'(1) << SW);
        return r[SW:0];
    endfunction

    // Pick a sample: full range, near zero or near either rail
    function automatic logic signed [SW-1:0] pick_sample();
        logic signed [SW-1:0] v;
        case ($urandom_range(0, 5))
            1: v = SW'($urandom_range(0, 2047)) - SW'(1024);
            2: v = S_MAX - SW'($urandom_range(0, 4095));
            3: v = S_MIN + SW'($urandom_range(0, 4095));
            4: v = $urandom_range(0, 1) ? S_MAX : S_MIN;
            default: v = SW'($urandom);
        endcase
        return v;
    endfunction

    // Queue n samples: mostly square-wave runs to excite resonance, plus noise
    task automatic fill_random(input int n);
        int left;
        int run;
        int period;
        logic signed [SW-1:0] amp;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 2) != 0) begin
                run = $urandom_range(8, 48);
                period = $urandom_range(1, 12);
                amp = pick_sample();
                for (int k = 0; k < run && left > 0; k++) begin
                    pending_samples.push_back(((k / period) % 2) ? -amp : amp);
                    left--;
                end
            end else begin
                pending_samples.push_back(pick_sample());
                left--;
            end
        end
    endtask

    // Hold until every queued word is accepted and answered, then let the block settle.
    // Check just after each edge so a word popped at that edge counts as pending.
    task automatic wait_drained();
        @(posedge aclk);
        #1;
        while (pending_samples.size() != 0 || s_valid || expected_out.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (20) @(posedge aclk);
    endtask

    // Write one register while the block is idle; mirror it in the predictor
    task automatic write_reg(input lhpf_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == lhpf_pkg::REG_POLE_COEF)
            coef_shadow = val;
        else
            gain_shadow = val[15:0];
    endtask

    // Sender: offer queued words in bursts with random gaps; predict on accept
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_sample_in <= '0;
            burst_left  <= 1;
            gap_left    <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_out.push_back(ladder_step(s_sample_in));
            if (!(s_valid && !s_ready)) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    s_valid     <= 1'b1;
                    s_sample_in <= pending_samples.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on a changing pattern; on request hold off for a long stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            hold_served <= 0;
            hold_left   <= 0;
            ready_mode  <= 0;
            ready_left  <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_served != hold_req) begin
            hold_served <= hold_req;
            hold_left   <= 500;
            m_ready     <= 1'b0;
        end else begin
            if (ready_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                ready_left <= $urandom_range(20, 200);
            end else begin
                ready_left <= ready_left - 1;
            end
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Monitor: compare each output word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_out.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none actual %0d", $time, m_sample_out);
            end else if (m_sample_out !== expected_out[0]) begin
                mismatch_count++;
                $display("%0t: sample_out mismatch, expected %0d actual %0d",
                         $time, expected_out[0], m_sample_out);
                void'(expected_out.pop_front());
            end else begin
                void'(expected_out.pop_front());
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] coef_plan [7];
        logic [15:0]      gain_plan [7];

        coef_shadow = 17'h10000;
        gain_shadow = '0;
        for (int k = 0; k < 4; k++)
            ladder_pole[k] = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset settings: poles hold at zero, output is the shaped input
        pending_samples.push_back('0);
        pending_samples.push_back(S_MAX);
        pending_samples.push_back(S_MIN);
        pending_samples.push_back(SW'(1));
        pending_samples.push_back(-SW'(1));
        pending_samples.push_back(SW'(24'h400000));
        wait_drained();

        // Zero coefficient: poles follow the input and settle on the negative rail
        write_reg(lhpf_pkg::REG_POLE_COEF, 17'h00000);
        write_reg(lhpf_pkg::REG_FEEDBACK_GAIN, 17'h00000);
        repeat (3) pending_samples.push_back(S_MIN);
        wait_drained();

        // Coefficient above one: poles hold; full positive input saturates the output
        write_reg(lhpf_pkg::REG_POLE_COEF, 17'h1FFFF);
        pending_samples.push_back(S_MAX);
        pending_samples.push_back(S_MAX);
        pending_samples.push_back(S_MIN);
        wait_drained();

        // Unity gain with bit 16 set: feedback drives the difference past the clamp
        write_reg(lhpf_pkg::REG_FEEDBACK_GAIN, 17'h11000);
        pending_samples.push_back(S_MAX);
        pending_samples.push_back(S_MIN);
        pending_samples.push_back('0);
        wait_drained();

        // Mid coefficient and gain on a short mixed run
        write_reg(lhpf_pkg::REG_POLE_COEF, 17'h08000);
        write_reg(lhpf_pkg::REG_FEEDBACK_GAIN, 17'h00800);
        for (int k = 0; k < 6; k++)
            pending_samples.push_back((k % 2) ? S_MIN : S_MAX - SW'(k));
        wait_drained();

        // Random phases across the register ranges, extremes included
        coef_plan = '{17'h0F000, 17'h00000, 17'h10000, 17'h0FFFF,
                      CFG_W'($urandom_range(0, 65536)), 17'h0C000,
                      CFG_W'($urandom_range(0, 65536))};
        gain_plan = '{16'h2000, 16'hFFFF, 16'hFFFF, 16'h0000,
                      16'($urandom), 16'h4000, 16'($urandom)};
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(lhpf_pkg::REG_POLE_COEF, coef_plan[ph]);
            write_reg(lhpf_pkg::REG_FEEDBACK_GAIN, {1'($urandom), gain_plan[ph]});
            fill_random(200);
            if (ph == 1 || ph == 4) begin
                while (pending_samples.size() > 100)
                    @(posedge aclk);
                hold_req <= hold_req + 1;
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
